>>> src/fbwc_pkg.sv
// fbwc_pkg: shared types and constants of the flash byte-write coalescer
`timescale 1ns / 1ps

package fbwc_pkg;

   // request kinds
   localparam logic [1:0] REQ_UNLOCK = 2'd0;
   localparam logic [1:0] REQ_WRITE  = 2'd1;
   localparam logic [1:0] REQ_LOCK   = 2'd2;

   // result kinds
   localparam logic [1:0] RES_STATUS  = 2'd0;
   localparam logic [1:0] RES_ERASE   = 2'd1;
   localparam logic [1:0] RES_PROGRAM = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_LOCKED    = 2'd1;
   localparam logic [1:0] ST_OUTSIDE   = 2'd2;
   localparam logic [1:0] ST_PROTECTED = 2'd3;

   // register indexes
   typedef enum logic [1:0] {
      REG_FLASH_BASE    = 2'd0,
      REG_FLASH_LIMIT   = 2'd1,
      REG_PROTECT_START = 2'd2,
      REG_PROTECT_LIMIT = 2'd3
   } reg_index_type;

   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [31:0] FLASH_BASE_RST    = 32'h0800_0000;
   localparam logic [31:0] FLASH_LIMIT_RST   = 32'h0808_0000;
   localparam logic [31:0] PROTECT_START_RST = 32'h0800_C000;
   localparam logic [31:0] PROTECT_LIMIT_RST = 32'h0801_0000;

   localparam logic [63:0] SHADOW_EMPTY = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [31:0] flash_base;
      logic [31:0] flash_limit;
      logic [31:0] protect_start;
      logic [31:0] protect_limit;
   } cfg_type;

endpackage

>>> src/flash_byte_write_coalescer_unit.sv
// flash_byte_write_coalescer_unit: top level of the flash byte-write coalescer
`timescale 1ns / 1ps
//
// Requests (unlock, byte write, lock) arrive on the req_ channel; each one
// yields one to three transfers on the rsp_ channel: an optional sector erase,
// an optional doubleword program, and always a status transfer with rsp_last.
// Byte writes are merged into a 64-bit shadow that is programmed when a write
// moves to another doubleword, when all eight bytes are filled, or on lock.
// The four window registers sit on the csr_ port; they are to be written only
// while idle, which the block itself does not enforce. A request is held in
// an input register, decided once the result slot is free, and its results
// are loaded into the result slot. The slot hands out one result per cycle
// while rsp_ready is high, in the order erase, program, status.
// The next request is decided in the cycle its predecessor's status leaves.
// When rsp_ready is low the result slot holds, one more request waits in the
// input register and then req_ready drops.
// Reset locks the flash, closes the shadow, clears the erased-sector map and
// loads the default windows; no clearing pass is needed.

module flash_byte_write_coalescer_unit #(
   parameter int SECTOR_BYTES     = 2048,
   parameter int SECTORS_PER_BANK = 128,
   parameter int NUM_SECTORS      = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_type,
   input  logic [31:0]                     req_byte_address,
   input  logic [7:0]                      req_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_result_kind,
   output logic                            rsp_erase_bank,
   output logic [6:0]                      rsp_erase_sector,
   output logic [31:0]                     rsp_program_address,
   output logic [63:0]                     rsp_program_word,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fbwc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int IDX_W = $clog2(NUM_SECTORS);

   fbwc_pkg::cfg_type cfg;

   fbwc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register
   logic        a_valid_ff, a_valid_in;
   logic [1:0]  a_type_ff;
   logic [31:0] a_addr_ff;
   logic [7:0]  a_data_ff;

   // block state
   logic                   locked_ff, locked_in;
   logic [31:0]            base_ff, base_in;
   logic [63:0]            data_ff, data_in;
   logic [7:0]             mask_ff, mask_in;
   logic [NUM_SECTORS-1:0] erased_ff, erased_in;

   // result slot
   logic        e_pend_ff, e_pend_in;
   logic        p_pend_ff, p_pend_in;
   logic        s_pend_ff, s_pend_in;
   logic        e_bank_ff;
   logic [6:0]  e_sector_ff;
   logic [31:0] p_addr_ff;
   logic [63:0] p_word_ff;
   logic [1:0]  s_status_ff;

   logic req_fire, rsp_fire, slot_free, load;

   assign rsp_valid = s_pend_ff;
   assign rsp_fire  = rsp_valid & rsp_ready;
   assign slot_free = ~s_pend_ff | (rsp_fire & ~e_pend_ff & ~p_pend_ff);
   assign load      = a_valid_ff & slot_free;
   assign req_ready = ~a_valid_ff | load;
   assign req_fire  = req_valid & req_ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (load) begin
         a_valid_in = 1'b0;
      end
   end

   // sector of the open shadow, relative to the flash window
   logic [31:0]      sec_off, sec_glob, sec_mod, bank_q, sec_r;
   logic [IDX_W-1:0] sec_idx;

   assign sec_off  = base_ff - cfg.flash_base;
   assign sec_glob = sec_off / 32'(SECTOR_BYTES);
   assign sec_mod  = sec_glob % 32'(NUM_SECTORS);
   assign sec_idx  = sec_mod[IDX_W-1:0];
   assign bank_q   = 32'(sec_idx) / 32'(SECTORS_PER_BANK);
   assign sec_r    = 32'(sec_idx) % 32'(SECTORS_PER_BANK);

   // request decision
   logic [1:0]  status;
   logic        is_write, ok_write, shadow_open, lock_do;
   logic        flush_old, flush_full, flush_lock, flush, erase;
   logic [31:0] dw;
   logic [5:0]  bit_sh;
   logic [7:0]  start_mask, new_mask;
   logic [63:0] start_data, new_data, flush_word;

   always_comb begin
      is_write = (a_type_ff == fbwc_pkg::REQ_WRITE);
      priority if (!is_write) begin
         status = fbwc_pkg::ST_OK;
      end else if (locked_ff) begin
         status = fbwc_pkg::ST_LOCKED;
      end else if (a_addr_ff < cfg.flash_base || a_addr_ff >= cfg.flash_limit) begin
         status = fbwc_pkg::ST_OUTSIDE;
      end else if (a_addr_ff >= cfg.protect_start && a_addr_ff < cfg.protect_limit) begin
         status = fbwc_pkg::ST_PROTECTED;
      end else begin
         status = fbwc_pkg::ST_OK;
      end

      ok_write    = is_write & (status == fbwc_pkg::ST_OK);
      shadow_open = |mask_ff;
      dw          = {a_addr_ff[31:3], 3'b000};
      bit_sh      = {a_addr_ff[2:0], 3'b000};

      flush_old  = ok_write & shadow_open & (dw != base_ff);
      start_mask = flush_old ? 8'h00 : mask_ff;
      start_data = flush_old ? fbwc_pkg::SHADOW_EMPTY : data_ff;
      new_mask   = start_mask | (8'h01 << a_addr_ff[2:0]);
      new_data   = (start_data & ~(64'hFF << bit_sh)) | (64'(a_data_ff) << bit_sh);
      flush_full = ok_write & ~flush_old & (new_mask == 8'hFF);

      lock_do    = (a_type_ff == fbwc_pkg::REQ_LOCK) & ~locked_ff;
      flush_lock = lock_do & shadow_open;
      flush      = flush_old | flush_full | flush_lock;
      erase      = flush & ~erased_ff[sec_idx];
      flush_word = flush_full ? new_data : data_ff;
   end

   // next state
   always_comb begin
      locked_in = locked_ff;
      base_in   = base_ff;
      data_in   = data_ff;
      mask_in   = mask_ff;
      erased_in = erased_ff;
      if (load) begin
         if (a_type_ff == fbwc_pkg::REQ_UNLOCK) begin
            locked_in = 1'b0;
            erased_in = '0;
         end
         if (lock_do) begin
            locked_in = 1'b1;
         end
         if (erase) begin
            erased_in[sec_idx] = 1'b1;
         end
         if (flush_full || flush_lock) begin
            base_in = 32'd0;
            data_in = fbwc_pkg::SHADOW_EMPTY;
            mask_in = 8'h00;
         end else if (ok_write) begin
            base_in = dw;
            data_in = new_data;
            mask_in = new_mask;
         end
      end
   end

   // result slot flags
   always_comb begin
      e_pend_in = e_pend_ff;
      p_pend_in = p_pend_ff;
      s_pend_in = s_pend_ff;
      if (rsp_fire) begin
         priority if (e_pend_ff) begin
            e_pend_in = 1'b0;
         end else if (p_pend_ff) begin
            p_pend_in = 1'b0;
         end else begin
            s_pend_in = 1'b0;
         end
      end
      if (load) begin
         e_pend_in = erase;
         p_pend_in = flush;
         s_pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         locked_ff  <= 1'b1;
         base_ff    <= 32'd0;
         data_ff    <= fbwc_pkg::SHADOW_EMPTY;
         mask_ff    <= 8'h00;
         erased_ff  <= '0;
         e_pend_ff  <= 1'b0;
         p_pend_ff  <= 1'b0;
         s_pend_ff  <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         locked_ff  <= locked_in;
         base_ff    <= base_in;
         data_ff    <= data_in;
         mask_ff    <= mask_in;
         erased_ff  <= erased_in;
         e_pend_ff  <= e_pend_in;
         p_pend_ff  <= p_pend_in;
         s_pend_ff  <= s_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_type_ff <= req_type;
         a_addr_ff <= req_byte_address;
         a_data_ff <= req_write_data;
      end
      if (load) begin
         e_bank_ff   <= bank_q[0];
         e_sector_ff <= sec_r[6:0];
         p_addr_ff   <= base_ff;
         p_word_ff   <= flush_word;
         s_status_ff <= status;
      end
   end

   // the slot hands out erase, then program, then status
   always_comb begin
      rsp_result_kind     = fbwc_pkg::RES_STATUS;
      rsp_erase_bank      = 1'b0;
      rsp_erase_sector    = 7'd0;
      rsp_program_address = 32'd0;
      rsp_program_word    = 64'd0;
      rsp_status          = fbwc_pkg::ST_OK;
      rsp_last            = 1'b0;
      priority if (e_pend_ff) begin
         rsp_result_kind  = fbwc_pkg::RES_ERASE;
         rsp_erase_bank   = e_bank_ff;
         rsp_erase_sector = e_sector_ff;
      end else if (p_pend_ff) begin
         rsp_result_kind     = fbwc_pkg::RES_PROGRAM;
         rsp_program_address = p_addr_ff;
         rsp_program_word    = p_word_ff;
      end else begin
         rsp_status = s_status_ff;
         rsp_last   = 1'b1;
      end
   end

`ifndef NO_ASSERTIONS
   // only the status transfer closes a request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_result_kind == fbwc_pkg::RES_STATUS)))
      else $error("last flag does not match status result");

   // an erase is always followed by its program
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_result_kind == fbwc_pkg::RES_ERASE)
      |=> (rsp_valid && rsp_result_kind == fbwc_pkg::RES_PROGRAM))
      else $error("erase not followed by program");

   // an open shadow only exists while unlocked
   assert property (@(posedge clock) disable iff (reset)
      (mask_ff != 8'h00) |-> !locked_ff)
      else $error("shadow open while locked");

   // a closed shadow reads as erased flash
   assert property (@(posedge clock) disable iff (reset)
      (mask_ff == 8'h00) |-> (data_ff == fbwc_pkg::SHADOW_EMPTY && base_ff == 32'd0))
      else $error("closed shadow not empty");

   // a pending erase or program always has its status behind it
   assert property (@(posedge clock) disable iff (reset)
      (e_pend_ff || p_pend_ff) |-> s_pend_ff)
      else $error("command pending without status");
`endif

endmodule

>>> src/fbwc_csr.sv
// fbwc_csr: apb-style configuration registers of the coalescer
`timescale 1ns / 1ps

module fbwc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fbwc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output fbwc_pkg::cfg_type                   cfg
);

   fbwc_pkg::cfg_type       cfg_ff;
   fbwc_pkg::cfg_type       cfg_in;
   fbwc_pkg::reg_index_type reg_idx;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = fbwc_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            fbwc_pkg::REG_FLASH_BASE:    cfg_in.flash_base    = csr_pwdata;
            fbwc_pkg::REG_FLASH_LIMIT:   cfg_in.flash_limit   = csr_pwdata;
            fbwc_pkg::REG_PROTECT_START: cfg_in.protect_start = csr_pwdata;
            fbwc_pkg::REG_PROTECT_LIMIT: cfg_in.protect_limit = csr_pwdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         fbwc_pkg::REG_FLASH_BASE:    csr_prdata = cfg_ff.flash_base;
         fbwc_pkg::REG_FLASH_LIMIT:   csr_prdata = cfg_ff.flash_limit;
         fbwc_pkg::REG_PROTECT_START: csr_prdata = cfg_ff.protect_start;
         fbwc_pkg::REG_PROTECT_LIMIT: csr_prdata = cfg_ff.protect_limit;
         default:                     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flash_base    <= fbwc_pkg::FLASH_BASE_RST;
         cfg_ff.flash_limit   <= fbwc_pkg::FLASH_LIMIT_RST;
         cfg_ff.protect_start <= fbwc_pkg::PROTECT_START_RST;
         cfg_ff.protect_limit <= fbwc_pkg::PROTECT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
